FILE: rtl/gcd_pkg.sv
// Shared types and constants for the genome compatibility distance block.
`timescale 1ns / 1ps

package gcd_pkg;

  // Field widths
  localparam int unsigned ID_W    = 16;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned ENTRY_W = ID_W + WGT_W;

  // Largest distance, unsigned Q12.12
  localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

  // Coefficient value 1.0 in Q4.12
  localparam logic [COEF_W-1:0] COEF_ONE = 16'd4096;

  // Operation codes
  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Register indexes
  typedef enum logic [1:0] {
    REG_EXCESS   = 2'd0,
    REG_DISJOINT = 2'd1,
    REG_WEIGHT   = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_e;

endpackage

FILE: rtl/gcd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module gcd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/gcd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module gcd_div #(
  parameter int unsigned DVD_W = 30,
  parameter int unsigned DVS_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0] quo_q, quo_d;

  logic [DVS_W:0]   shifted;
  logic             ge;

  // One trial subtraction per cycle; dividend bits shift out, quotient bits in
  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    ge      = (shifted >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? DVS_W'(shifted - {1'b0, dvs_q}) : DVS_W'(shifted);
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/genome_compatibility_distance.sv
// Top level: link list storage, merge sequencer and distance arithmetic.
`timescale 1ns / 1ps

// Usage
// - Input channel: operation_i, link_id_i, weight_i are taken at a rising edge
//   with start high and busy low. Load A / load B store one link in a cycle and
//   keep busy low, so loads go in one per cycle. A load into a full list is
//   dropped. Operation code 3 is dropped.
// - A compute transaction raises busy. The merge takes one step per cycle,
//   advancing one list, or both on a matching id (one RAM read per list per
//   cycle), then the shared multiplier runs up to three products and the shared
//   bit-serial divider runs up to two divisions of CW+21 quotient bits each
//   (CW = $clog2(MAX_LINKS+1)); none run when both lists are empty. Busy drops
//   right after the result. Both lists are empty afterwards.
// - Result channel: done_o is high for one cycle with distance_o and the counts.
//   The receiver must take it then; there is no back-pressure.
// - Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once;
//   only write while busy is low. Index 3 is ignored.
// - Reset clears both list counts and sets all coefficients to 1.0. List RAM
//   contents are not cleared; only entries below the counts are read.

module genome_compatibility_distance #(
  parameter int unsigned MAX_LINKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [15:0] link_id_i,
  input  logic signed [15:0] weight_i,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // results
  output logic        done_o,
  output logic [23:0] distance_o,
  output logic [8:0]  excess_count_o,
  output logic [9:0]  disjoint_count_o,
  output logic [8:0]  matching_count_o,
  output logic        both_empty_o
);

  localparam int unsigned IW  = $clog2(MAX_LINKS);
  localparam int unsigned CW  = $clog2(MAX_LINKS + 1);
  localparam int unsigned DSW = CW + 1;
  localparam int unsigned SW  = CW + 17;
  localparam int unsigned PW  = SW + gcd_pkg::COEF_W;
  localparam int unsigned DVW = CW + 21;
  localparam int unsigned TW  = DVW + 1;
  localparam int unsigned EW  = gcd_pkg::ENTRY_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MERGE = 4'd1;
  localparam logic [3:0] S_MULE  = 4'd2;
  localparam logic [3:0] S_MULD  = 4'd3;
  localparam logic [3:0] S_DGO1  = 4'd4;
  localparam logic [3:0] S_DW1   = 4'd5;
  localparam logic [3:0] S_MULW  = 4'd6;
  localparam logic [3:0] S_DGO2  = 4'd7;
  localparam logic [3:0] S_DW2   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]     state_q, state_d;
  logic [CW-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0]  ia_q, ia_d, ib_q, ib_d;
  logic [CW-1:0]  exc_q, exc_d, n_q, n_d, mat_q, mat_d;
  logic [DSW-1:0] dis_q, dis_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic [DVW-1:0] acc_q, acc_d;
  logic [DVW-1:0] dist_q, dist_d;
  logic [23:0]    out_q, out_d;
  logic           empty_q, empty_d;
  logic [15:0]    ce_q, cd_q, cw_q;

  logic           accept;
  logic           we_a, we_b;
  logic [EW-1:0]  wdata;
  logic [EW-1:0]  rdata_a, rdata_b;
  logic [15:0]    id_a, id_b;
  logic signed [15:0] w_a, w_b;
  logic signed [16:0] wdiff;
  logic [16:0]    wabs;
  logic           in_range;
  logic [CW-1:0]  rem_a, rem_b;

  logic [15:0]    mul_a;
  logic [SW-1:0]  mul_b;
  logic [PW-1:0]  prod;

  logic           div_start, div_done;
  logic [CW-1:0]  div_divisor;
  logic [DVW-1:0] div_quot;
  logic [TW-1:0]  total;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ce_q <= gcd_pkg::COEF_ONE;
      cd_q <= gcd_pkg::COEF_ONE;
      cw_q <= gcd_pkg::COEF_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gcd_pkg::REG_EXCESS:   ce_q <= cfg_wdata_i;
        gcd_pkg::REG_DISJOINT: cd_q <= cfg_wdata_i;
        gcd_pkg::REG_WEIGHT:   cw_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // List storage: one RAM per list holding {id, weight}
  assign we_a  = accept && (operation_i == gcd_pkg::OP_LOAD_A) &&
                 (cnt_a_q < CW'(MAX_LINKS));
  assign we_b  = accept && (operation_i == gcd_pkg::OP_LOAD_B) &&
                 (cnt_b_q < CW'(MAX_LINKS));
  assign wdata = {link_id_i, weight_i};

  gcd_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_LINKS)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(cnt_a_q[IW-1:0]),
    .wdata_i(wdata),
    .raddr_i(ia_d[IW-1:0]),
    .rdata_o(rdata_a)
  );

  gcd_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_LINKS)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(cnt_b_q[IW-1:0]),
    .wdata_i(wdata),
    .raddr_i(ib_d[IW-1:0]),
    .rdata_o(rdata_b)
  );

  // Merge step datapath: read data follows the next read pointers
  assign id_a     = rdata_a[EW-1:gcd_pkg::WGT_W];
  assign id_b     = rdata_b[EW-1:gcd_pkg::WGT_W];
  assign w_a      = rdata_a[gcd_pkg::WGT_W-1:0];
  assign w_b      = rdata_b[gcd_pkg::WGT_W-1:0];
  assign wdiff    = {w_a[15], w_a} - {w_b[15], w_b};
  assign wabs     = wdiff[16] ? 17'(-wdiff) : 17'(wdiff);
  assign in_range = (ia_q < cnt_a_q) && (ib_q < cnt_b_q);
  assign rem_a    = cnt_a_q - ia_q;
  assign rem_b    = cnt_b_q - ib_q;

  // Shared multiplier, operands picked by the sequencer
  always_comb begin
    case (state_q)
      S_MULE: begin
        mul_a = ce_q;
        mul_b = SW'(exc_q);
      end
      S_MULD: begin
        mul_a = cd_q;
        mul_b = SW'(dis_q);
      end
      default: begin
        mul_a = cw_q;
        mul_b = sum_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Shared divider
  assign div_start   = (state_q == S_DGO1) || (state_q == S_DGO2);
  assign div_divisor = (state_q == S_DGO1) ? n_q : mat_q;

  gcd_div #(
    .DVD_W(DVW),
    .DVS_W(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(acc_q),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  assign total = (state_q == S_DW2) ? (TW'(dist_q) + TW'(div_quot)) : TW'(dist_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_a_d = we_a ? cnt_a_q + CW'(1) : cnt_a_q;
    cnt_b_d = we_b ? cnt_b_q + CW'(1) : cnt_b_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    exc_d   = exc_q;
    n_d     = n_q;
    mat_d   = mat_q;
    dis_d   = dis_q;
    sum_d   = sum_q;
    acc_d   = acc_q;
    dist_d  = dist_q;
    out_d   = out_q;
    empty_d = empty_q;
    unique case (state_q)
      S_IDLE: begin
        ia_d = '0;
        ib_d = '0;
        if (accept && (operation_i == gcd_pkg::OP_COMPUTE)) begin
          mat_d   = '0;
          dis_d   = '0;
          sum_d   = '0;
          empty_d = 1'b0;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        if (in_range) begin
          if (id_a == id_b) begin
            sum_d = sum_q + SW'(wabs);
            mat_d = mat_q + CW'(1);
            ia_d  = ia_q + CW'(1);
            ib_d  = ib_q + CW'(1);
          end else if (id_a < id_b) begin
            dis_d = dis_q + DSW'(1);
            ia_d  = ia_q + CW'(1);
          end else begin
            dis_d = dis_q + DSW'(1);
            ib_d  = ib_q + CW'(1);
          end
        end else begin
          exc_d   = (rem_a > rem_b) ? rem_a : rem_b;
          n_d     = (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;
          state_d = S_MULE;
        end
      end
      S_MULE: begin
        if (n_q == '0) begin
          empty_d = 1'b1;
          out_d   = '0;
          state_d = S_DONE;
        end else begin
          acc_d   = DVW'(prod) + DVW'({n_q, {gcd_pkg::FRAC_W{1'b0}}});
          state_d = S_MULD;
        end
      end
      S_MULD: begin
        acc_d   = acc_q + DVW'(prod);
        state_d = S_DGO1;
      end
      S_DGO1: begin
        state_d = S_DW1;
      end
      S_DW1: begin
        if (div_done) begin
          dist_d  = div_quot;
          state_d = S_MULW;
        end
      end
      S_MULW: begin
        if (mat_q == '0) begin
          out_d   = (total > TW'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : 24'(total);
          state_d = S_DONE;
        end else begin
          acc_d   = DVW'(prod >> gcd_pkg::FRAC_W);
          state_d = S_DGO2;
        end
      end
      S_DGO2: begin
        state_d = S_DW2;
      end
      S_DW2: begin
        if (div_done) begin
          out_d   = (total > TW'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : 24'(total);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cnt_a_d = '0;
        cnt_b_d = '0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ia_q    <= ia_d;
      ib_q    <= ib_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    exc_q   <= exc_d;
    n_q     <= n_d;
    mat_q   <= mat_d;
    dis_q   <= dis_d;
    sum_q   <= sum_d;
    acc_q   <= acc_d;
    dist_q  <= dist_d;
    out_q   <= out_d;
    empty_q <= empty_d;
  end

  // Result ports
  assign done_o           = (state_q == S_DONE);
  assign distance_o       = out_q;
  assign excess_count_o   = 9'(exc_q);
  assign disjoint_count_o = 10'(dis_q);
  assign matching_count_o = 9'(mat_q);
  assign both_empty_o     = empty_q;

endmodule
